// ----- src/tsse_pkg.sv -----
// Package for the typed stable sort engine: element type codes, sizes, command struct, compare.
`default_nettype none
package tsse_pkg;

  localparam int unsigned DefCapacity = 64;
  localparam int unsigned ValueW      = 32;
  localparam int unsigned TypeW       = 2;

  localparam logic [TypeW-1:0] TY_S16 = 2'd0;
  localparam logic [TypeW-1:0] TY_S32 = 2'd1;
  localparam logic [TypeW-1:0] TY_F32 = 2'd2;
  localparam logic [TypeW-1:0] TY_S8  = 2'd3;

  // Datapath command bundle from the sequencer
  typedef struct packed {
    logic st_we;      // element store write
    logic st_copy;    // store write data from scratch (else from input)
    logic sc_we;      // scratch write (merge step)
    logic lvalid;     // left run still has elements
    logic rvalid;     // right run still has elements
    logic out_ld;     // load result register from store read
    logic out_err;    // load result register with the error item
    logic out_final;  // tlast for a loaded result
  } dp_cmd_t;

  // True when a sorts at or before b (a <= b) under the element type.
  function automatic logic elem_le(input logic [TypeW-1:0] ty,
                                   input logic [ValueW-1:0] a,
                                   input logic [ValueW-1:0] b);
    logic [ValueW-1:0] ka;
    logic [ValueW-1:0] kb;
    logic nan_any;
    logic zeros;
    logic le;
    ka = '0;
    kb = '0;
    nan_any = 1'b0;
    zeros = 1'b0;
    le = 1'b1;
    unique case (ty)
      TY_S16: begin
        ka = {16'h0, a[15:0] ^ 16'h8000};
        kb = {16'h0, b[15:0] ^ 16'h8000};
        le = (ka <= kb);
      end
      TY_S8: begin
        ka = {24'h0, a[7:0] ^ 8'h80};
        kb = {24'h0, b[7:0] ^ 8'h80};
        le = (ka <= kb);
      end
      TY_F32: begin
        nan_any = ((a[30:23] == 8'hff) && (a[22:0] != '0)) ||
                  ((b[30:23] == 8'hff) && (b[22:0] != '0));
        zeros = (a[30:0] == '0) && (b[30:0] == '0);
        // sign-magnitude to monotonic unsigned key
        ka = a[31] ? ~a : (a | 32'h8000_0000);
        kb = b[31] ? ~b : (b | 32'h8000_0000);
        le = nan_any || zeros || (ka <= kb);
      end
      default: begin
        ka = a ^ 32'h8000_0000;
        kb = b ^ 32'h8000_0000;
        le = (ka <= kb);
      end
    endcase
    return le;
  endfunction

endpackage
`default_nettype wire

// ----- src/tsse_ram.sv -----
// Generic RAM: one write port, two registered read ports.
`default_nettype none
module tsse_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 64
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_a_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_b_i,
  output logic      [Width-1:0]         rdata_a_o,
  output logic      [Width-1:0]         rdata_b_o
);
  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_a_o <= mem_q[raddr_a_i];
    rdata_b_o <= mem_q[raddr_b_i];
  end
endmodule
`default_nettype wire

// ----- src/tsse_datapath.sv -----
// Datapath: element store, merge scratch, comparator and result register.
`default_nettype none
module tsse_datapath #(
  parameter int unsigned CAPACITY = tsse_pkg::DefCapacity,
  localparam int unsigned AW = $clog2(CAPACITY)
) (
  input  wire logic                         clk_i,
  input  wire tsse_pkg::dp_cmd_t            cmd_i,
  input  wire logic [tsse_pkg::TypeW-1:0]   elem_type_i,
  input  wire logic [tsse_pkg::ValueW-1:0]  in_value_i,
  input  wire logic [AW-1:0]                st_waddr_i,
  input  wire logic [AW-1:0]                st_raddr_a_i,
  input  wire logic [AW-1:0]                st_raddr_b_i,
  input  wire logic [AW-1:0]                sc_addr_i,
  output logic                              take_left_o,
  output logic [tsse_pkg::ValueW-1:0]       out_value_o,
  output logic                              out_last_o,
  output logic                              out_err_o
);
  logic [tsse_pkg::ValueW-1:0] st_rd_a;
  logic [tsse_pkg::ValueW-1:0] st_rd_b;
  logic [tsse_pkg::ValueW-1:0] sc_rd;
  logic [tsse_pkg::ValueW-1:0] sc_rd_unused;
  logic [tsse_pkg::ValueW-1:0] st_wdata;
  logic [tsse_pkg::ValueW-1:0] sc_wdata;
  logic                        le;

  assign st_wdata = cmd_i.st_copy ? sc_rd : in_value_i;
  assign le = tsse_pkg::elem_le(elem_type_i, st_rd_a, st_rd_b);
  // left wins ties, so equal keys keep load order
  assign take_left_o = !cmd_i.rvalid || (cmd_i.lvalid && le);
  assign sc_wdata = take_left_o ? st_rd_a : st_rd_b;

  tsse_ram #(.Width(tsse_pkg::ValueW), .Depth(CAPACITY)) u_store (
    .clk_i     (clk_i),
    .we_i      (cmd_i.st_we),
    .waddr_i   (st_waddr_i),
    .wdata_i   (st_wdata),
    .raddr_a_i (st_raddr_a_i),
    .raddr_b_i (st_raddr_b_i),
    .rdata_a_o (st_rd_a),
    .rdata_b_o (st_rd_b)
  );

  tsse_ram #(.Width(tsse_pkg::ValueW), .Depth(CAPACITY)) u_scratch (
    .clk_i     (clk_i),
    .we_i      (cmd_i.sc_we),
    .waddr_i   (sc_addr_i),
    .wdata_i   (sc_wdata),
    .raddr_a_i (sc_addr_i),
    .raddr_b_i (sc_addr_i),
    .rdata_a_o (sc_rd),
    .rdata_b_o (sc_rd_unused)
  );

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_err) begin
      out_value_o <= '0;
      out_last_o  <= 1'b1;
      out_err_o   <= 1'b1;
    end else if (cmd_i.out_ld) begin
      out_value_o <= st_rd_a;
      out_last_o  <= cmd_i.out_final;
      out_err_o   <= 1'b0;
    end
  end
endmodule
`default_nettype wire

// ----- src/tsse_ctrl.sv -----
// Sequencer: load counting, top-down merge schedule on a range stack, copy-back and emit.
`default_nettype none
module tsse_ctrl #(
  parameter int unsigned CAPACITY = tsse_pkg::DefCapacity,
  localparam int unsigned AW  = $clog2(CAPACITY),
  localparam int unsigned IW  = $clog2(CAPACITY + 1),
  localparam int unsigned SD  = $clog2(CAPACITY) + 2,
  localparam int unsigned SIW = $clog2(SD),
  localparam int unsigned SPW = $clog2(SD + 1)
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  input  wire logic              in_last_i,
  output logic                   in_ready_o,
  output logic                   out_valid_o,
  input  wire logic              out_ready_i,
  input  wire logic              take_left_i,
  output tsse_pkg::dp_cmd_t      cmd_o,
  output logic [AW-1:0]          st_waddr_o,
  output logic [AW-1:0]          st_raddr_a_o,
  output logic [AW-1:0]          st_raddr_b_o,
  output logic [AW-1:0]          sc_addr_o
);
  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_TOP   = 3'd1;
  localparam logic [2:0] S_MRD   = 3'd2;
  localparam logic [2:0] S_MCMP  = 3'd3;
  localparam logic [2:0] S_CRD   = 3'd4;
  localparam logic [2:0] S_CWR   = 3'd5;
  localparam logic [2:0] S_ERD   = 3'd6;
  localparam logic [2:0] S_OUT   = 3'd7;

  localparam logic [1:0] PH_LEFT  = 2'd0;
  localparam logic [1:0] PH_RIGHT = 2'd1;
  localparam logic [1:0] PH_MERGE = 2'd2;

  logic [2:0]     state_q, state_d;
  logic [SPW-1:0] sp_q, sp_d;
  logic [IW-1:0]  stk_lo_q [SD];
  logic [IW-1:0]  stk_hi_q [SD];
  logic [1:0]     stk_ph_q [SD];
  logic [IW-1:0]  cnt_q, cnt_d;
  logic           ovf_q, ovf_d;
  logic [IW-1:0]  n_q, n_d;
  logic [IW-1:0]  i_q, i_d, j_q, j_d, k_q, k_d;
  logic [IW-1:0]  lo_q, lo_d, mid_q, mid_d, hi_q, hi_d;
  logic           valid_q, valid_d;
  logic           fin_q, fin_d;

  logic [SIW-1:0] top;
  logic [SIW-1:0] push_at;
  logic [IW-1:0]  t_lo, t_hi, t_n, t_mid;
  logic [1:0]     t_ph;
  logic [IW:0]    half_sum;
  logic           accept;
  logic           full;
  logic           lvalid, rvalid;
  logic           stk_set_ph, stk_push;
  logic [1:0]     set_ph;
  logic [IW-1:0]  push_lo, push_hi;

  assign top      = SIW'(sp_q - SPW'(1));
  assign push_at  = SIW'(sp_q);
  assign t_lo     = stk_lo_q[top];
  assign t_hi     = stk_hi_q[top];
  assign t_ph     = stk_ph_q[top];
  assign t_n      = t_hi - t_lo;
  assign half_sum = ({1'b0, t_n} + (IW+1)'(1)) >> 1;
  assign t_mid    = t_lo + IW'(half_sum);

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = valid_q;
  assign accept      = in_valid_i && in_ready_o;
  assign full        = (cnt_q == IW'(CAPACITY));
  assign lvalid      = (i_q < mid_q);
  assign rvalid      = (j_q < hi_q);

  always_comb begin
    state_d = state_q;
    sp_d = sp_q;
    cnt_d = cnt_q;
    ovf_d = ovf_q;
    n_d = n_q;
    i_d = i_q; j_d = j_q; k_d = k_q;
    lo_d = lo_q; mid_d = mid_q; hi_d = hi_q;
    valid_d = valid_q;
    fin_d = fin_q;
    cmd_o = '0;
    cmd_o.lvalid = lvalid;
    cmd_o.rvalid = rvalid;
    cmd_o.out_final = (k_q + IW'(1) == n_q);
    st_waddr_o   = AW'(cnt_q);
    st_raddr_a_o = AW'(i_q);
    st_raddr_b_o = AW'(j_q);
    sc_addr_o    = AW'(k_q);
    stk_set_ph = 1'b0;
    stk_push = 1'b0;
    set_ph = PH_LEFT;
    push_lo = t_lo;
    push_hi = t_mid;
    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          if (!ovf_q && !full) begin
            cmd_o.st_we = 1'b1;
            cnt_d = cnt_q + IW'(1);
          end else begin
            ovf_d = 1'b1;
          end
          if (in_last_i) begin
            cnt_d = '0;
            ovf_d = 1'b0;
            if (ovf_q || full) begin
              cmd_o.out_err = 1'b1;
              valid_d = 1'b1;
              fin_d = 1'b1;
              state_d = S_OUT;
            end else begin
              n_d = cnt_q + IW'(1);
              stk_push = 1'b1;
              push_lo = '0;
              push_hi = cnt_q + IW'(1);
              sp_d = SPW'(1);
              state_d = S_TOP;
            end
          end
        end
      end
      S_TOP: begin
        if (sp_q == '0) begin
          k_d = '0;
          state_d = S_ERD;
        end else if (t_ph == PH_LEFT) begin
          if (t_n < IW'(2)) begin
            sp_d = sp_q - SPW'(1);
          end else begin
            stk_set_ph = 1'b1;
            set_ph = PH_RIGHT;
            stk_push = 1'b1;
            sp_d = sp_q + SPW'(1);
          end
        end else if (t_ph == PH_RIGHT) begin
          stk_set_ph = 1'b1;
          set_ph = PH_MERGE;
          stk_push = 1'b1;
          push_lo = t_mid;
          push_hi = t_hi;
          sp_d = sp_q + SPW'(1);
        end else begin
          sp_d = sp_q - SPW'(1);
          i_d = t_lo; j_d = t_mid; k_d = t_lo;
          lo_d = t_lo; mid_d = t_mid; hi_d = t_hi;
          state_d = S_MRD;
        end
      end
      S_MRD: begin
        if (k_q == hi_q) begin
          k_d = lo_q;
          state_d = S_CRD;
        end else begin
          state_d = S_MCMP;
        end
      end
      S_MCMP: begin
        cmd_o.sc_we = 1'b1;
        if (take_left_i) i_d = i_q + IW'(1);
        else j_d = j_q + IW'(1);
        k_d = k_q + IW'(1);
        state_d = S_MRD;
      end
      S_CRD: begin
        if (k_q == hi_q) state_d = S_TOP;
        else state_d = S_CWR;
      end
      S_CWR: begin
        cmd_o.st_we = 1'b1;
        cmd_o.st_copy = 1'b1;
        st_waddr_o = AW'(k_q);
        k_d = k_q + IW'(1);
        state_d = S_CRD;
      end
      S_ERD: begin
        st_raddr_a_o = AW'(k_q);
        // read data is registered: result loads in the next state
        state_d = S_OUT;
        cmd_o.out_ld = 1'b0;
      end
      S_OUT: begin
        if (!valid_q) begin
          cmd_o.out_ld = 1'b1;
          valid_d = 1'b1;
          fin_d = cmd_o.out_final;
        end else if (out_ready_i) begin
          valid_d = 1'b0;
          if (fin_q) begin
            state_d = S_IDLE;
          end else begin
            k_d = k_q + IW'(1);
            state_d = S_ERD;
          end
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      sp_q    <= '0;
      cnt_q   <= '0;
      ovf_q   <= 1'b0;
      valid_q <= 1'b0;
      fin_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      sp_q    <= sp_d;
      cnt_q   <= cnt_d;
      ovf_q   <= ovf_d;
      valid_q <= valid_d;
      fin_q   <= fin_d;
    end
  end

  always_ff @(posedge clk_i) begin
    n_q <= n_d;
    i_q <= i_d; j_q <= j_d; k_q <= k_d;
    lo_q <= lo_d; mid_q <= mid_d; hi_q <= hi_d;
    if (stk_set_ph) stk_ph_q[top] <= set_ph;
    if (stk_push) begin
      stk_lo_q[push_at] <= push_lo;
      stk_hi_q[push_at] <= push_hi;
      stk_ph_q[push_at] <= PH_LEFT;
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni) sp_q <= SPW'(SD))
    else $error("range stack overrun");
  assert property (@(posedge clk_i) disable iff (!rst_ni) cnt_q <= IW'(CAPACITY))
    else $error("element count beyond capacity");
  assert property (@(posedge clk_i) disable iff (!rst_ni) !(in_ready_o && out_valid_o))
    else $error("load and emit overlap");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   out_valid_o |-> (state_q == S_OUT))
    else $error("result valid outside emit");
endmodule
`default_nettype wire

// ----- src/typed_stable_sort_engine_unit.sv -----
// Top level of the typed stable sort engine.
//  channel | dir | handshake              | payload
//  s_axis  | in  | s_axis_tvalid/tready   | tdata value[31:0], tlast last
//  m_axis  | out | m_axis_tvalid/tready   | tdata sorted_value, tlast final_res,
//          |     |                        | tuser overflow_error
//  cfg     | in  | cfg_valid_i/cfg_ready_o| cfg_data_i element_type[1:0]
// Loading takes one cycle per item. After the last item the top-down merge sort runs
// on the store RAM: each merged element is read, then compared into scratch, and each
// copied-back element is read, then written back, between range-stack steps; the RAM ports set this.
// Emit reads each result from the store, registers it, then presents it; a stalled result holds.
// Config is accepted only while loading, so a sort never sees the type change.
// Reset clears control only; element type resets to signed 32-bit.
`default_nettype none
module typed_stable_sort_engine_unit #(
  parameter int unsigned CAPACITY = tsse_pkg::DefCapacity
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [31:0] s_axis_tdata,   // value[31:0]
  input  wire logic        s_axis_tlast,
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic      [31:0] m_axis_tdata,   // sorted_value[31:0]
  output logic             m_axis_tlast,
  output logic             m_axis_tuser,   // overflow_error
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic [1:0]  cfg_data_i
);
  localparam int unsigned AW = $clog2(CAPACITY);

  tsse_pkg::dp_cmd_t              cmd;
  logic [AW-1:0]                  st_waddr, st_raddr_a, st_raddr_b, sc_addr;
  logic                           take_left;
  logic [tsse_pkg::TypeW-1:0]     elem_type_q;

  assign cfg_ready_o = s_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      elem_type_q <= tsse_pkg::TY_S32;
    end else if (cfg_valid_i && cfg_ready_o) begin
      elem_type_q <= cfg_data_i;
    end
  end

  tsse_ctrl #(.CAPACITY(CAPACITY)) u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (s_axis_tvalid),
    .in_last_i    (s_axis_tlast),
    .in_ready_o   (s_axis_tready),
    .out_valid_o  (m_axis_tvalid),
    .out_ready_i  (m_axis_tready),
    .take_left_i  (take_left),
    .cmd_o        (cmd),
    .st_waddr_o   (st_waddr),
    .st_raddr_a_o (st_raddr_a),
    .st_raddr_b_o (st_raddr_b),
    .sc_addr_o    (sc_addr)
  );

  tsse_datapath #(.CAPACITY(CAPACITY)) u_dp (
    .clk_i        (clk_i),
    .cmd_i        (cmd),
    .elem_type_i  (elem_type_q),
    .in_value_i   (s_axis_tdata),
    .st_waddr_i   (st_waddr),
    .st_raddr_a_i (st_raddr_a),
    .st_raddr_b_i (st_raddr_b),
    .sc_addr_i    (sc_addr),
    .take_left_o  (take_left),
    .out_value_o  (m_axis_tdata),
    .out_last_o   (m_axis_tlast),
    .out_err_o    (m_axis_tuser)
  );
endmodule
`default_nettype wire

// ----- test/typed_stable_sort_engine_unit_test.sv -----
// Testbench for the typed stable sort engine: random lists, per-type sort prediction, stream checks.
`default_nettype none
module typed_stable_sort_engine_unit_test;

  localparam int unsigned Cap = 64;

  typedef struct {
    logic [31:0] value;
    logic        last;
  } list_item_t;

  typedef struct {
    logic [31:0] value;
    logic        final_res;
    logic        overflow_error;
  } sorted_item_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [31:0] s_axis_tdata = '0;
  logic        s_axis_tlast = 1'b0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [31:0] m_axis_tdata;
  logic        m_axis_tlast;
  logic        m_axis_tuser;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [1:0]  cfg_data_i = tsse_pkg::TY_S32;

  typed_stable_sort_engine_unit #(.CAPACITY(Cap)) DUT (
    .clk_i, .rst_ni,
    .s_axis_tvalid, .s_axis_tready,
    .s_axis_tdata,  // value[31:0]
    .s_axis_tlast,
    .m_axis_tvalid, .m_axis_tready,
    .m_axis_tdata,  // sorted_value[31:0]
    .m_axis_tlast,
    .m_axis_tuser,  // overflow_error
    .cfg_valid_i, .cfg_ready_o, .cfg_data_i
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  list_item_t   pending_items[$];
  sorted_item_t sorted_expect[$];
  logic [31:0]  list_buf[Cap];
  logic [31:0]  merge_buf[Cap];
  int           list_count = 0;
  bit           list_ovf = 1'b0;
  logic [1:0]   elem_type = tsse_pkg::TY_S32;
  int           fail_count = 0;
  bit           no_idle = 1'b0;
  int           send_gap = 0;
  int           recv_gap = 0;
  int           hold_cnt = 0;
  int           hold_reqs = 0;
  int           hold_done = 0;
  int           n_over[2] = '{0, 1};

  function automatic int pick_gap();
    int r;
    r = $urandom_range(99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(3, 1);
    return $urandom_range(40, 10);
  endfunction

  // a sorts at or before b under the current element type
  function automatic bit sorts_le(logic [31:0] a, logic [31:0] b);
    bit a_nan;
    bit b_nan;
    case (elem_type)
      tsse_pkg::TY_S16: return $signed(a[15:0]) <= $signed(b[15:0]);
      tsse_pkg::TY_S8:  return $signed(a[7:0]) <= $signed(b[7:0]);
      tsse_pkg::TY_F32: begin
        a_nan = (a[30:23] == 8'hff) && (a[22:0] != 0);
        b_nan = (b[30:23] == 8'hff) && (b[22:0] != 0);
        if (a_nan || b_nan) return 1'b1;
        if (a[30:0] == 0 && b[30:0] == 0) return 1'b1;
        if (a[31] != b[31]) return a[31];
        if (!a[31]) return a[30:0] <= b[30:0];
        return a[30:0] >= b[30:0];
      end
      default: return $signed(a) <= $signed(b);
    endcase
  endfunction

  // top-down merge sort, left half takes the odd element
  task automatic merge_sort_span(int lo, int hi);
    int mid;
    int i;
    int j;
    int k;
    if (hi - lo < 2) return;
    mid = lo + (hi - lo + 1) / 2;
    merge_sort_span(lo, mid);
    merge_sort_span(mid, hi);
    i = lo;
    j = mid;
    for (k = lo; k < hi; k++) begin
      if (j >= hi || (i < mid && sorts_le(list_buf[i], list_buf[j]))) begin
        merge_buf[k] = list_buf[i];
        i++;
      end else begin
        merge_buf[k] = list_buf[j];
        j++;
      end
    end
    for (k = lo; k < hi; k++) list_buf[k] = merge_buf[k];
  endtask

  task automatic take_item(logic [31:0] v, logic lst);
    sorted_item_t r;
    if (!list_ovf) begin
      if (list_count < Cap) begin
        list_buf[list_count] = v;
        list_count++;
      end else begin
        list_ovf = 1'b1;
      end
    end
    if (lst) begin
      if (list_ovf) begin
        r.value = '0;
        r.final_res = 1'b1;
        r.overflow_error = 1'b1;
        sorted_expect.push_back(r);
      end else begin
        merge_sort_span(0, list_count);
        for (int k = 0; k < list_count; k++) begin
          r.value = list_buf[k];
          r.final_res = (k == list_count - 1);
          r.overflow_error = 1'b0;
          sorted_expect.push_back(r);
        end
      end
      list_count = 0;
      list_ovf = 1'b0;
    end
  endtask

  // driver
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready) begin
        take_item(s_axis_tdata, s_axis_tlast);
        void'(pending_items.pop_front());
      end
      if (!(s_axis_tvalid && !s_axis_tready)) begin
        if (send_gap > 0) begin
          send_gap--;
          s_axis_tvalid <= 1'b0;
        end else if (pending_items.size() > 0) begin
          s_axis_tvalid <= 1'b1;
          s_axis_tdata <= pending_items[0].value;
          s_axis_tlast <= pending_items[0].last;
          send_gap = no_idle ? 0 : pick_gap();
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // monitor and sink
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (cfg_valid_i && cfg_ready_o) elem_type <= cfg_data_i;
      if (m_axis_tvalid && m_axis_tready) begin
        if (sorted_expect.size() == 0) begin
          $error("unexpected item: value %h", m_axis_tdata);
          fail_count++;
        end else begin
          if (m_axis_tdata !== sorted_expect[0].value) begin
            $error("sorted_value expected %h got %h", sorted_expect[0].value, m_axis_tdata);
            fail_count++;
          end
          if (m_axis_tlast !== sorted_expect[0].final_res) begin
            $error("final_res expected %b got %b", sorted_expect[0].final_res, m_axis_tlast);
            fail_count++;
          end
          if (m_axis_tuser !== sorted_expect[0].overflow_error) begin
            $error("overflow_error expected %b got %b",
                   sorted_expect[0].overflow_error, m_axis_tuser);
            fail_count++;
          end
          void'(sorted_expect.pop_front());
        end
      end
      if (hold_reqs != hold_done) begin
        hold_done++;
        hold_cnt = 1500;
      end
      if (hold_cnt > 0) begin
        hold_cnt--;
        m_axis_tready <= 1'b0;
      end else if (recv_gap > 0 && !no_idle) begin
        recv_gap--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
        if ($urandom_range(3) == 0) recv_gap = pick_gap();
      end
    end
  end

  task automatic push_list(logic [31:0] vals[$]);
    list_item_t it;
    foreach (vals[k]) begin
      it.value = vals[k];
      it.last = (k == vals.size() - 1);
      pending_items.push_back(it);
    end
  endtask

  function automatic logic [31:0] rand_value(logic [1:0] ty);
    int r;
    r = $urandom_range(9);
    if (r < 4) return $urandom();
    if (r < 6) return {2'($urandom_range(3)), 28'h0, 2'($urandom_range(3))}; // duplicate keys
    if (ty == tsse_pkg::TY_F32) begin
      case ($urandom_range(5))
        0: return 32'h0000_0000;
        1: return 32'h8000_0000;
        2: return 32'h7fc0_0000 | $urandom_range(255);
        3: return 32'h7f80_0000;
        4: return 32'hff80_0000;
        default: return {1'($urandom_range(1)), 8'h7f, 23'($urandom_range(3))};
      endcase
    end
    return $urandom() ^ 32'h0000_8080;
  endfunction

  task automatic settle();
    while (pending_items.size() > 0 || s_axis_tvalid || sorted_expect.size() > 0)
      @(posedge clk_i);
    repeat (50) @(posedge clk_i);
  endtask

  task automatic set_type(logic [1:0] ty);
    cfg_valid_i <= 1'b1;
    cfg_data_i <= ty;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  initial begin
    logic [31:0] vals[$];
    int n;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: default type first, then each type with its extremes and ties
    vals = '{32'h7fff_ffff, 32'h8000_0000, 32'h0, 32'hffff_ffff, 32'h1};
    push_list(vals);
    settle();
    set_type(tsse_pkg::TY_S16);
    vals = '{32'hffff_7fff, 32'h0000_8000, 32'h1234_0005, 32'h0000_ffff, 32'habcd_0005};
    push_list(vals);
    settle();
    set_type(tsse_pkg::TY_S8);
    vals = '{32'h0000_007f, 32'hffff_ff80, 32'h0000_1105, 32'hffff_0005, 32'h42};
    push_list(vals);
    settle();
    set_type(tsse_pkg::TY_F32);
    vals = '{32'h3f80_0000, 32'h8000_0000, 32'h7fc0_0000, 32'h0000_0000,
             32'hff80_0000, 32'h7f80_0000, 32'hbf80_0000, 32'h7fc0_0001};
    push_list(vals);
    vals = '{32'h5555_aaaa};
    push_list(vals);
    settle();

    for (int ph = 0; ph < 5; ph++) begin
      set_type(2'(ph % 4));
      no_idle = (ph % 5 == 4);
      if (ph == 2) hold_reqs++;
      for (int l = 0; l < 2; l++) begin
        n = ($urandom_range(7) == 0) ? $urandom_range(12, 6) : $urandom_range(4, 1);
        vals = {};
        for (int k = 0; k < n; k++) vals.push_back(rand_value(2'(ph % 4)));
        push_list(vals);
      end
      settle();
    end

    // capacity edge: exactly full, then one over
    foreach (n_over[i]) begin
      vals = {};
      for (int k = 0; k < Cap + n_over[i]; k++) vals.push_back($urandom());
      push_list(vals);
    end
    settle();
    set_type(tsse_pkg::TY_S32);
    vals = '{32'h9, 32'h3};
    push_list(vals);
    settle();
    repeat (100) @(posedge clk_i);

    if (fail_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  initial begin
    #(20 * 600000);
    $display("*** FAILED ***");
    $finish;
  end

endmodule
`default_nettype wire
